[hw/rtl/bpa_pkg.sv]
// Package for the buddy page allocator: default size, result codes, controller
// states and the command and status bundles between controller and datapath.
// Depends on nothing.
package bpa_pkg;

	localparam int DEF_NUM_PAGES = 4096;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_NOSPACE = 2'd1,
		STS_BADFREE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_AL_ROOT,
		ST_AL_DESC,
		ST_FR_WALK,
		ST_MARK,
		ST_UP,
		ST_RESULT
	} state_t;

	typedef enum logic [2:0] {
		RD_NODE,
		RD_LEFT,
		RD_LEFT_NEXT,
		RD_PARENT,
		RD_SIB,
		RD_PSIB
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_INIT,
		WR_MARK,
		WR_PARENT
	} wr_sel_t;

	typedef struct packed {
		rd_sel_t rd_sel;
		wr_sel_t wr_sel;
		logic    init_step;
		logic    load;
		logic    descend;
		logic    ascend;
		logic    set_status;
		status_t status_val;
		logic    res_load;
	} cmd_t;

	typedef struct packed {
		logic init_last;
		logic is_free;
		logic too_big;
		logic bad_page;
		logic root_short;
		logic at_want;
		logic desc_last;
		logic hit_zero;
		logic at_root;
		logic parent_root;
		logic out_free;
	} stat_t;

	// Size code of a request: ceil(log2(pages)) + 1, with zero pages taken as one.
	function automatic logic [3:0] want_code(input logic [12:0] pages);
		logic [12:0] m;
		logic [3:0]  lg;
		m  = (pages == 13'd0) ? 13'd0 : pages - 13'd1;
		lg = 4'd0;
		for (int i = 0; i < 13; i++) begin
			if (m[i]) begin
				lg = 4'(i + 1);
			end
		end
		return lg + 4'd1;
	endfunction

endpackage

[hw/rtl/buddy_page_allocator.sv]
// Binary buddy page allocator: a tree of longest-free-block codes in one memory with
// one read and one write port, walked one level per cycle by a controller.
// One request at a time: the next is taken in the cycle after its result is loaded.
// After reset a clearing pass fills the tree before any request.
module buddy_page_allocator #(
	parameter int NUM_PAGES = bpa_pkg::DEF_NUM_PAGES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        op,
	input  logic [12:0] req_pages,
	input  logic [12:0] page_index,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic [11:0] start_page,
	output logic [12:0] block_pages
);

	bpa_pkg::cmd_t  cmd;
	bpa_pkg::stat_t st;

	bpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.st        (st),
		.cmd       (cmd)
	);

	bpa_datapath #(
		.NUM_PAGES (NUM_PAGES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.op          (op),
		.req_pages   (req_pages),
		.page_index  (page_index),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.start_page  (start_page),
		.block_pages (block_pages)
	);

endmodule

[hw/rtl/bpa_ctrl.sv]
// Controller of the buddy page allocator: sequences the clearing pass, the
// tree walks and the result hand-off. Depends on bpa_pkg.
module bpa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  bpa_pkg::stat_t st,
	output bpa_pkg::cmd_t  cmd
);

	bpa_pkg::state_t state_q;
	bpa_pkg::state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpa_pkg::ST_INIT;
		end else begin
			state_q <= state_nx;
		end
	end

	assign req_stall = (state_q != bpa_pkg::ST_IDLE);

	always_comb begin
		state_nx       = state_q;
		cmd            = '0;
		cmd.rd_sel     = bpa_pkg::RD_NODE;
		cmd.wr_sel     = bpa_pkg::WR_NONE;
		cmd.status_val = bpa_pkg::STS_OK;
		unique case (state_q)
			bpa_pkg::ST_INIT: begin
				cmd.wr_sel    = bpa_pkg::WR_INIT;
				cmd.init_step = 1'b1;
				if (st.init_last) begin
					state_nx = bpa_pkg::ST_IDLE;
				end
			end
			bpa_pkg::ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_nx = bpa_pkg::ST_DECODE;
				end
			end
			bpa_pkg::ST_DECODE: begin
				if (!st.is_free) begin
					if (st.too_big) begin
						cmd.set_status = 1'b1;
						cmd.status_val = bpa_pkg::STS_NOSPACE;
						state_nx       = bpa_pkg::ST_RESULT;
					end else begin
						state_nx = bpa_pkg::ST_AL_ROOT;
					end
				end else begin
					if (st.bad_page) begin
						cmd.set_status = 1'b1;
						cmd.status_val = bpa_pkg::STS_BADFREE;
						state_nx       = bpa_pkg::ST_RESULT;
					end else begin
						state_nx = bpa_pkg::ST_FR_WALK;
					end
				end
			end
			bpa_pkg::ST_AL_ROOT: begin
				if (st.root_short) begin
					cmd.set_status = 1'b1;
					cmd.status_val = bpa_pkg::STS_NOSPACE;
					state_nx       = bpa_pkg::ST_RESULT;
				end else if (st.at_want) begin
					state_nx = bpa_pkg::ST_MARK;
				end else begin
					cmd.rd_sel = bpa_pkg::RD_LEFT;
					state_nx   = bpa_pkg::ST_AL_DESC;
				end
			end
			bpa_pkg::ST_AL_DESC: begin
				cmd.descend = 1'b1;
				if (st.desc_last) begin
					state_nx = bpa_pkg::ST_MARK;
				end else begin
					cmd.rd_sel = bpa_pkg::RD_LEFT_NEXT;
				end
			end
			bpa_pkg::ST_FR_WALK: begin
				if (st.hit_zero) begin
					state_nx = bpa_pkg::ST_MARK;
				end else if (st.at_root) begin
					cmd.set_status = 1'b1;
					cmd.status_val = bpa_pkg::STS_BADFREE;
					state_nx       = bpa_pkg::ST_RESULT;
				end else begin
					cmd.ascend = 1'b1;
					cmd.rd_sel = bpa_pkg::RD_PARENT;
				end
			end
			bpa_pkg::ST_MARK: begin
				cmd.wr_sel     = bpa_pkg::WR_MARK;
				cmd.set_status = 1'b1;
				cmd.status_val = bpa_pkg::STS_OK;
				if (st.at_root) begin
					state_nx = bpa_pkg::ST_RESULT;
				end else begin
					cmd.rd_sel = bpa_pkg::RD_SIB;
					state_nx   = bpa_pkg::ST_UP;
				end
			end
			bpa_pkg::ST_UP: begin
				cmd.wr_sel = bpa_pkg::WR_PARENT;
				if (st.parent_root) begin
					state_nx = bpa_pkg::ST_RESULT;
				end else begin
					cmd.rd_sel = bpa_pkg::RD_PSIB;
				end
			end
			bpa_pkg::ST_RESULT: begin
				if (st.out_free) begin
					cmd.res_load = 1'b1;
					state_nx     = bpa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = bpa_pkg::ST_INIT;
			end
		endcase
	end

endmodule

[hw/rtl/bpa_datapath.sv]
// Datapath of the buddy page allocator: the tree memory of size codes, the
// walk registers, the merge logic and the result register. Depends on bpa_pkg.
module bpa_datapath #(
	parameter int NUM_PAGES = bpa_pkg::DEF_NUM_PAGES
) (
	input  logic           clk,
	input  logic           arst_n,
	input  bpa_pkg::cmd_t  cmd,
	output bpa_pkg::stat_t st,
	input  logic           op,
	input  logic [12:0]    req_pages,
	input  logic [12:0]    page_index,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output logic [1:0]     status,
	output logic [11:0]    start_page,
	output logic [12:0]    block_pages
);

	localparam int LOG2P = $clog2(NUM_PAGES);
	localparam int TW    = LOG2P + 1;
	localparam int CW    = $clog2(LOG2P + 2);
	localparam int DEPTH = 1 << TW;

	// A node holds 0 when allocated, otherwise k for a longest free block of 2^(k-1).
	logic [CW-1:0]   tree_mem_q [0:DEPTH-1];
	logic [CW-1:0]   rd_q;

	logic [TW-1:0]   node_q;
	logic [CW-1:0]   sc_q;
	logic [CW-1:0]   want_q;
	logic [CW-1:0]   val_q;
	logic            op_q;
	logic            too_big_q;
	logic            bad_page_q;
	bpa_pkg::status_t pend_q;
	logic [LOG2P-1:0] blk_start_q;
	logic [TW-1:0]   blk_size_q;

	logic            rsp_valid_q;
	bpa_pkg::status_t status_q;
	logic [11:0]     start_q;
	logic [12:0]     size_q;

	logic [TW-1:0]   leaf;
	logic [TW-1:0]   parent;
	logic            go_right;
	logic [TW-1:0]   node_nx;
	logic [TW-1:0]   rd_addr;
	logic            wr_en;
	logic [TW-1:0]   wr_addr;
	logic [CW-1:0]   wr_data;
	logic [CW-1:0]   mark_val;
	logic [CW-1:0]   merged;
	logic [TW-1:0]   start_full;

	assign leaf     = TW'(32'(NUM_PAGES) + 32'(page_index));
	assign parent   = node_q >> 1;
	assign go_right = (rd_q < want_q);
	assign node_nx  = {node_q[TW-2:0], go_right};
	assign mark_val = op_q ? sc_q : '0;
	assign merged   = ((val_q == sc_q) && (rd_q == sc_q)) ? sc_q + CW'(1) :
	                  ((val_q > rd_q) ? val_q : rd_q);
	assign start_full = node_q << (sc_q - CW'(1));

	always_comb begin
		rd_addr = node_q;
		case (cmd.rd_sel)
			bpa_pkg::RD_NODE:      rd_addr = node_q;
			bpa_pkg::RD_LEFT:      rd_addr = {node_q[TW-2:0], 1'b0};
			bpa_pkg::RD_LEFT_NEXT: rd_addr = {node_nx[TW-2:0], 1'b0};
			bpa_pkg::RD_PARENT:    rd_addr = parent;
			bpa_pkg::RD_SIB:       rd_addr = node_q ^ TW'(1);
			bpa_pkg::RD_PSIB:      rd_addr = parent ^ TW'(1);
			default:               rd_addr = node_q;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = node_q;
		wr_data = sc_q;
		case (cmd.wr_sel)
			bpa_pkg::WR_INIT: begin
				wr_en = 1'b1;
			end
			bpa_pkg::WR_MARK: begin
				wr_en   = 1'b1;
				wr_data = mark_val;
			end
			bpa_pkg::WR_PARENT: begin
				wr_en   = 1'b1;
				wr_addr = parent;
				wr_data = merged;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tree_mem_q[wr_addr] <= wr_data;
		end
		rd_q <= tree_mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q <= TW'(1);
			sc_q   <= CW'(LOG2P + 1);
		end else if (cmd.init_step) begin
			node_q <= node_q + TW'(1);
			if (((node_q + TW'(1)) & node_q) == '0) begin
				sc_q <= sc_q - CW'(1);
			end
		end else if (cmd.load) begin
			if (op) begin
				node_q <= leaf;
				sc_q   <= CW'(1);
			end else begin
				node_q <= TW'(1);
				sc_q   <= CW'(LOG2P + 1);
			end
		end else if (cmd.descend) begin
			node_q <= node_nx;
			sc_q   <= sc_q - CW'(1);
		end else if (cmd.ascend || (cmd.wr_sel == bpa_pkg::WR_PARENT)) begin
			node_q <= parent;
			sc_q   <= sc_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q       <= op;
			want_q     <= CW'(bpa_pkg::want_code(req_pages));
			too_big_q  <= (32'(req_pages) > 32'(NUM_PAGES));
			bad_page_q <= (32'(page_index) >= 32'(NUM_PAGES));
		end
		if (cmd.wr_sel == bpa_pkg::WR_MARK) begin
			val_q       <= mark_val;
			blk_start_q <= start_full[LOG2P-1:0];
			blk_size_q  <= TW'(1) << (sc_q - CW'(1));
		end else if (cmd.wr_sel == bpa_pkg::WR_PARENT) begin
			val_q <= merged;
		end
		if (cmd.set_status) begin
			pend_q <= cmd.status_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status_q <= pend_q;
			if (pend_q == bpa_pkg::STS_OK) begin
				start_q <= 12'(blk_start_q);
				size_q  <= 13'(blk_size_q);
			end else begin
				start_q <= '0;
				size_q  <= '0;
			end
		end
	end

	assign st.init_last   = (node_q == {TW{1'b1}});
	assign st.is_free     = op_q;
	assign st.too_big     = too_big_q;
	assign st.bad_page    = bad_page_q;
	assign st.root_short  = (rd_q < want_q);
	assign st.at_want     = (sc_q == want_q);
	assign st.desc_last   = ((sc_q - CW'(1)) == want_q);
	assign st.hit_zero    = (rd_q == '0);
	assign st.at_root     = (node_q == TW'(1));
	assign st.parent_root = (parent == TW'(1));
	assign st.out_free    = !rsp_valid_q || !rsp_stall;

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign start_page  = start_q;
	assign block_pages = size_q;

endmodule

[tb/bpa_tb_pkg.sv]
`timescale 1ns / 100ps
// Request codes and the result record shared by the allocator testbench and its checker.
// Depends on bpa_pkg for the status codes.
package bpa_tb_pkg;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef struct packed {
		bpa_pkg::status_t status;
		logic [11:0]      start;
		logic [12:0]      pages;
	} page_result_t;

endpackage

[tb/buddy_page_allocator_checker.sv]
`timescale 1ns / 100ps
// Checker for the buddy page allocator: keeps its own longest-free tree, predicts each
// result from the accepted requests and compares it with what the block returns.
// Depends on bpa_pkg and bpa_tb_pkg.
module buddy_page_allocator_checker
	import bpa_pkg::*;
	import bpa_tb_pkg::*;
#(
	parameter int NUM_PAGES = DEF_NUM_PAGES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  logic        op,
	input  logic [12:0] req_pages,
	input  logic [12:0] page_index,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  logic [1:0]  status,
	input  logic [11:0] start_page,
	input  logic [12:0] block_pages,
	output int          open_count,
	output int          errors
);

	logic [12:0]  largest_free [2*NUM_PAGES-1];
	page_result_t awaited [$];
	page_result_t oldest;
	int           mismatches = 0;

	assign errors = mismatches;

	task automatic report_mismatch(input string msg);
		$display("%0t: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// A node whose children are both wholly free merges back into one free block.
	function automatic void fix_ancestors(input int unsigned node, input int unsigned span);
		int unsigned l;
		int unsigned r;
		while (node > 0) begin
			node = (node - 1) / 2;
			span = span << 1;
			l = largest_free[2*node+1];
			r = largest_free[2*node+2];
			largest_free[node] = (l + r == span) ? 13'(span) : 13'((l > r) ? l : r);
		end
	endfunction

	function automatic page_result_t predict_request(input op_t kind,
			input logic [12:0] pages, input logic [12:0] page);
		page_result_t res;
		int unsigned  want;
		int unsigned  node;
		int unsigned  span;
		int unsigned  base;
		int unsigned  left;
		res.status = STS_OK;
		res.start = '0;
		res.pages = '0;
		if (kind == OP_ALLOC) begin
			want = 1;
			while (want < pages) begin
				want = want << 1;
			end
			if (pages > NUM_PAGES || largest_free[0] < want) begin
				res.status = STS_NOSPACE;
				return res;
			end
			node = 0;
			span = NUM_PAGES;
			base = 0;
			while (span > want) begin
				left = 2 * node + 1;
				span = span >> 1;
				if (largest_free[left] >= want) begin
					node = left;
				end else begin
					node = left + 1;
					base = base + span;
				end
			end
			largest_free[node] = '0;
			fix_ancestors(node, span);
			res.start = 12'(base);
			res.pages = 13'(span);
		end else begin
			if (page >= NUM_PAGES) begin
				res.status = STS_BADFREE;
				return res;
			end
			node = NUM_PAGES - 1 + page;
			span = 1;
			while (largest_free[node] != 0) begin
				if (node == 0) begin
					res.status = STS_BADFREE;
					return res;
				end
				node = (node - 1) / 2;
				span = span << 1;
			end
			largest_free[node] = 13'(span);
			fix_ancestors(node, span);
			res.start = 12'((node - (NUM_PAGES / span - 1)) * span);
			res.pages = 13'(span);
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < 2*NUM_PAGES-1; n++) begin
				largest_free[n] = 13'(NUM_PAGES >> ($clog2(n + 2) - 1));
			end
			awaited.delete();
			open_count <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (awaited.size() == 0) begin
					report_mismatch($sformatf(
						"result with no request outstanding: status %0d start_page %0d block_pages %0d",
						status, start_page, block_pages));
				end else begin
					oldest = awaited.pop_front();
					if (status !== oldest.status) begin
						report_mismatch($sformatf("status got %0d, expected %0d",
							status, oldest.status));
					end
					if (start_page !== oldest.start) begin
						report_mismatch($sformatf("start_page got %0d, expected %0d",
							start_page, oldest.start));
					end
					if (block_pages !== oldest.pages) begin
						report_mismatch($sformatf("block_pages got %0d, expected %0d",
							block_pages, oldest.pages));
					end
				end
			end
			if (req_valid && !req_stall) begin
				awaited.push_back(predict_request(op_t'(op), req_pages, page_index));
			end
			open_count <= awaited.size();
		end
	end

endmodule

[tb/buddy_page_allocator_tb.sv]
`timescale 1ns / 100ps
// Top of the buddy page allocator testbench: clock, reset, request and stall stimulus,
// and the verdict. Depends on bpa_pkg, bpa_tb_pkg, the checker and the allocator.
module buddy_page_allocator_tb;
	import bpa_pkg::*;
	import bpa_tb_pkg::*;

	localparam int PAGES           = DEF_NUM_PAGES;
	localparam int RANDOM_REQUESTS = 1300;
	localparam int CYCLE_LIMIT     = 2000000;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	logic        op;
	logic [12:0] req_pages;
	logic [12:0] page_index;
	logic        rsp_valid;
	logic        rsp_stall;
	logic [1:0]  status;
	logic [11:0] start_page;
	logic [12:0] block_pages;
	int          open_count;
	int          errors;

	op_t          sent_ops [$];
	page_result_t live_blocks [$];
	op_t          kind_done;
	page_result_t granted;
	int unsigned  cycles = 0;

	buddy_page_allocator #(
		.NUM_PAGES(PAGES)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.op         (op),
		.req_pages  (req_pages),
		.page_index (page_index),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.start_page (start_page),
		.block_pages(block_pages)
	);

	buddy_page_allocator_checker #(
		.NUM_PAGES(PAGES)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.op         (op),
		.req_pages  (req_pages),
		.page_index (page_index),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.start_page (start_page),
		.block_pages(block_pages),
		.open_count (open_count),
		.errors     (errors)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d results outstanding", cycles, open_count);
			$display("buddy_page_allocator_tb: FAIL");
			$finish;
		end
	end

	// Blocks that the allocator has handed out feed the well-formed free requests.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall && sent_ops.size() != 0) begin
			kind_done = sent_ops.pop_front();
			if (status == STS_OK) begin
				if (kind_done == OP_ALLOC) begin
					granted.status = STS_OK;
					granted.start = start_page;
					granted.pages = block_pages;
					live_blocks.push_back(granted);
				end else begin
					for (int k = live_blocks.size() - 1; k >= 0; k--) begin
						if (live_blocks[k].start == start_page) begin
							live_blocks.delete(k);
						end
					end
				end
			end
		end
	end

	task automatic issue(input op_t kind, input logic [12:0] pages, input logic [12:0] page);
		op <= kind;
		req_pages <= pages;
		page_index <= page;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		sent_ops.push_back(kind);
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		do @(posedge clk); while (open_count != 0);
	endtask

	// The first hold-off comes once results start to flow, so the block backs up.
	initial begin
		int mode;
		int span;
		rsp_stall <= 1'b0;
		do @(posedge clk); while (!rsp_valid);
		rsp_stall <= 1'b1;
		repeat (300) @(posedge clk);
		forever begin
			mode = $urandom_range(0, 39);
			span = $urandom_range(10, 80);
			if (mode == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(150, 300)) @(posedge clk);
			end else if (mode < 12) begin
				rsp_stall <= 1'b0;
				repeat (span) @(posedge clk);
			end else if (mode < 26) begin
				repeat (span) begin
					rsp_stall <= ($urandom_range(0, 2) == 0);
					@(posedge clk);
				end
			end else if (mode < 38) begin
				repeat (span) begin
					rsp_stall <= ($urandom_range(0, 1) == 0);
					@(posedge clk);
				end
			end else begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	initial begin
		int           burst_left;
		int           gap;
		int           alloc_bias;
		int           pick;
		int           slot;
		logic [12:0]  amount;
		page_result_t victim;

		arst_n <= 1'b0;
		req_valid <= 1'b0;
		op <= OP_ALLOC;
		req_pages <= '0;
		page_index <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		issue(OP_FREE, 13'($urandom), 13'd0);
		issue(OP_FREE, 13'($urandom), 13'd4096);
		issue(OP_FREE, 13'($urandom), 13'd8191);
		issue(OP_ALLOC, 13'd0, 13'($urandom));
		issue(OP_ALLOC, 13'd8191, 13'($urandom));
		issue(OP_ALLOC, 13'd4097, 13'($urandom));
		issue(OP_ALLOC, 13'd4096, 13'($urandom));
		issue(OP_FREE, 13'($urandom), 13'd0);
		issue(OP_ALLOC, 13'd4096, 13'($urandom));
		issue(OP_ALLOC, 13'd1, 13'($urandom));
		issue(OP_FREE, 13'($urandom), 13'd4095);
		issue(OP_ALLOC, 13'd3, 13'($urandom));
		issue(OP_ALLOC, 13'd1, 13'($urandom));
		issue(OP_ALLOC, 13'd2, 13'($urandom));
		issue(OP_ALLOC, 13'd2048, 13'($urandom));
		issue(OP_ALLOC, 13'd2048, 13'($urandom));
		issue(OP_FREE, 13'($urandom), 13'd2);
		issue(OP_ALLOC, 13'd1, 13'($urandom));
		issue(OP_FREE, 13'($urandom), 13'd5);
		issue(OP_FREE, 13'($urandom), 13'd3000);
		issue(OP_FREE, 13'($urandom), 13'd4);
		issue(OP_FREE, 13'($urandom), 13'd6);
		issue(OP_FREE, 13'($urandom), 13'd0);
		issue(OP_ALLOC, 13'd4096, 13'($urandom));
		issue(OP_FREE, 13'($urandom), 13'd1234);
		settle();

		burst_left = 0;
		alloc_bias = 50;
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 100 == 0) begin
				alloc_bias = $urandom_range(25, 75);
			end
			if (n == RANDOM_REQUESTS / 2) begin
				settle();
			end else if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = $urandom_range(0, 12);
				if (gap != 0) begin
					req_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end else begin
				burst_left--;
			end

			pick = $urandom_range(0, 99);
			if (pick < alloc_bias || (pick < 90 && live_blocks.size() == 0)) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					amount = 13'($urandom_range(1, 16));
				end else if (pick < 90) begin
					amount = 13'($urandom_range(17, 256));
				end else if (pick < 97) begin
					amount = 13'($urandom_range(257, 4096));
				end else if (pick == 97) begin
					amount = '0;
				end else begin
					amount = 13'($urandom_range(4097, 8191));
				end
				issue(OP_ALLOC, amount, 13'($urandom));
			end else if (pick < 90) begin
				slot = $urandom_range(0, live_blocks.size() - 1);
				victim = live_blocks[slot];
				live_blocks.delete(slot);
				issue(OP_FREE, 13'($urandom),
					13'(victim.start + $urandom_range(0, victim.pages - 1)));
			end else begin
				issue(OP_FREE, 13'($urandom), 13'($urandom_range(0, 8191)));
			end
		end

		settle();
		repeat (40) @(posedge clk);
		if (errors == 0) begin
			$display("buddy_page_allocator_tb: PASS");
		end else begin
			$display("buddy_page_allocator_tb: FAIL");
		end
		$finish;
	end

endmodule
